/* rtl/core/aesctr_pkg.sv */
// ----------------------------------------------------------------------------
// AES-CTR keystream generator package
// Shared item types, configuration indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int SEGMENT_BLOCKS = 1048576;
    localparam int BSR_W = $clog2(SEGMENT_BLOCKS);

    localparam logic [2:0] CFG_KEY0     = 3'd0;
    localparam logic [2:0] CFG_KEY1     = 3'd1;
    localparam logic [2:0] CFG_KEY2     = 3'd2;
    localparam logic [2:0] CFG_KEY3     = 3'd3;
    localparam logic [2:0] CFG_KEY_SIZE = 3'd4;
    localparam logic [2:0] CFG_SEED_HI  = 3'd5;
    localparam logic [2:0] CFG_SEED_LO  = 3'd6;

    typedef struct packed {
        logic [4:0] byte_count;
        logic       end_of_request;
    } t_in_item;

    typedef struct packed {
        logic [63:0] stream_high;
        logic [63:0] stream_low;
        logic [4:0]  valid_count;
        logic        final_block;
    } t_out_item;

    typedef enum logic [1:0] {
        ACT_OUT     = 2'd0,
        ACT_REPLACE = 2'd1,
        ACT_NEWKEY  = 2'd2,
        ACT_NEWCTR  = 2'd3
    } t_act;

    typedef struct packed {
        logic       kexp_start;
        logic       enc_start;
        t_act       act;
        logic [4:0] n;
        logic       eor;
    } t_dp_cmd;

    typedef struct packed {
        logic key_dirty;
        logic kexp_busy;
        logic enc_done;
        logic out_full;
    } t_dp_stat;

endpackage

/* rtl/core/aes_ctr_keystream_generator_rekeying_top.sv */
// ----------------------------------------------------------------------------
// AES-CTR keystream generator with key refresh
// An item takes 0 to 5 encryptions. After a key change the 4 * (Nr + 1) round key
// words are built one per cycle. Sync reset clears config, key, counter.
// ----------------------------------------------------------------------------
module aes_ctr_keystream_generator_rekeying_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  aesctr_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aesctr_pkg::t_out_item o_out_data
);
    import aesctr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    aesctr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    aesctr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/aesctr_ctrl.sv */
// ----------------------------------------------------------------------------
// AES-CTR controller
// Plans the encryptions of one item and sequences the datapath.
// ----------------------------------------------------------------------------
module aesctr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aesctr_pkg::t_in_item i_in_data,
    input  aesctr_pkg::t_dp_stat i_stat,
    output aesctr_pkg::t_dp_cmd  o_cmd
);
    import aesctr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DISP = 4'b0010,
        S_KEXP = 4'b0100,
        S_ENC  = 4'b1000
    } t_state;

    typedef enum logic [5:0] {
        P_PRE  = 6'b000001,
        P_OUT  = 6'b000010,
        P_POST = 6'b000100,
        P_EOR  = 6'b001000,
        P_KEY  = 6'b010000,
        P_CTR  = 6'b100000
    } t_phase;

    localparam logic [BSR_W-1:0] SEG_LAST = BSR_W'(SEGMENT_BLOCKS - 1);

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [4:0]       r_n, n_n;
    logic             r_eor, n_eor;
    logic [BSR_W-1:0] r_bsr, n_bsr;
    logic             r_seg_hit, n_seg_hit;

    logic full, partial, need, hit;
    t_act act;
    t_phase next_phase;

    always_comb begin
        full    = r_n[4];
        partial = (r_n != 5'd0) && !r_n[4];
        hit     = (r_bsr == SEG_LAST);
        need = 1'b0;
        act  = ACT_REPLACE;
        next_phase = P_PRE;
        unique case (r_phase)
            P_PRE: begin
                need = partial && (r_bsr != '0);
                next_phase = P_OUT;
            end
            P_OUT: begin
                need = (r_n != 5'd0);
                act  = ACT_OUT;
                next_phase = P_POST;
            end
            P_POST: begin
                need = (full && r_seg_hit) || partial;
                next_phase = P_EOR;
            end
            P_EOR: begin
                need = r_eor && (r_bsr != '0);
                next_phase = P_KEY;
            end
            P_KEY: begin
                need = r_eor;
                act  = ACT_NEWKEY;
                next_phase = P_CTR;
            end
            P_CTR: begin
                need = r_eor;
                act  = ACT_NEWCTR;
                next_phase = P_PRE;
            end
            default: begin
                need = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_n       = r_n;
        n_eor     = r_eor;
        n_bsr     = r_bsr;
        n_seg_hit = r_seg_hit;
        o_cmd.kexp_start = 1'b0;
        o_cmd.enc_start  = 1'b0;
        o_cmd.act        = act;
        o_cmd.n          = r_n;
        o_cmd.eor        = r_eor;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n = (i_in_data.byte_count > 5'd16) ? 5'd16 : i_in_data.byte_count;
                    n_eor   = i_in_data.end_of_request;
                    n_phase = P_PRE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (need && i_stat.key_dirty) begin
                    o_cmd.kexp_start = 1'b1;
                    n_state = S_KEXP;
                end else if (!(need && act == ACT_OUT && i_stat.out_full)) begin
                    if (r_phase == P_OUT && full) begin
                        n_bsr     = hit ? '0 : r_bsr + 1'b1;
                        n_seg_hit = hit;
                    end
                    if ((r_phase == P_POST && partial) || (r_phase == P_EOR && r_eor)) begin
                        n_bsr = '0;
                    end
                    n_phase = next_phase;
                    if (need) begin
                        o_cmd.enc_start = 1'b1;
                        n_state = S_ENC;
                    end else if (r_phase == P_CTR) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_KEXP: begin
                if (!i_stat.kexp_busy) begin
                    n_state = S_DISP;
                end
            end
            S_ENC: begin
                if (i_stat.enc_done) begin
                    n_state = (r_phase == P_PRE) ? S_IDLE : S_DISP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= P_PRE;
            r_bsr     <= '0;
            r_seg_hit <= 1'b0;
            r_n       <= 5'd0;
            r_eor     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_bsr     <= n_bsr;
            r_seg_hit <= n_seg_hit;
            r_n       <= n_n;
            r_eor     <= n_eor;
        end
    end

endmodule

/* rtl/core/aesctr_dp.sv */
// ----------------------------------------------------------------------------
// AES-CTR datapath
// Key expansion into round key banks, one AES round per cycle, counter,
// working key and result register.
// ----------------------------------------------------------------------------
module aesctr_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  aesctr_pkg::t_dp_cmd  i_cmd,
    output aesctr_pkg::t_dp_stat o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output aesctr_pkg::t_out_item o_out_data
);
    import aesctr_pkg::*;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[b[4*((c+r)&3)+r]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = t[i];
        end
        return o;
    endfunction

    // Configuration and working state.
    logic [63:0]  r_cfg_key [4];
    logic [1:0]   r_cfg_size;
    logic [63:0]  r_cfg_seed_lo;
    logic [255:0] r_wkey, n_wkey;
    logic [1:0]   r_mode, n_mode;
    logic [127:0] r_ctr, n_ctr;
    logic [127:0] r_pend, n_pend;
    logic         r_dirty, n_dirty;

    // Key expansion.
    logic         r_kbusy, n_kbusy;
    logic [5:0]   r_wi, n_wi;
    logic [2:0]   r_wj, n_wj;
    logic [7:0]   r_rcon, n_rcon;
    logic [31:0]  r_win [8];
    logic [31:0]  new_word, prev_w, old_w, x_w;
    logic [3:0]   nk, nr;
    logic [5:0]   last_wi;

    // Round key banks.
    logic [31:0]  r_rk_mem [4][16];
    logic [31:0]  r_rk_rd [4];
    logic [3:0]   raddr;

    // Encryption.
    logic         r_ebusy, n_ebusy;
    logic [3:0]   r_rnd, n_rnd;
    logic [127:0] r_s, n_s;
    t_act         r_act, n_act;
    logic [4:0]   r_n, n_n;
    logic         r_eor, n_eor;
    logic         done;
    logic [127:0] rk, blk, masked;

    // Result register.
    logic         r_ovalid, n_ovalid;
    t_out_item    r_out, n_out;

    always_comb begin
        unique case (r_mode)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
        nr      = nk + 4'd6;
        last_wi = {nr, 2'b00} + 6'd3;
    end

    always_comb begin
        prev_w = r_win[0];
        old_w  = r_win[nk[2:0] - 3'd1];
        if (r_wj == 3'd0) begin
            x_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {r_rcon, 24'd0};
        end else if (nk == 4'd8 && r_wj == 3'd4) begin
            x_w = sub_word(prev_w);
        end else begin
            x_w = prev_w;
        end
        if (r_wi < {2'b00, nk}) begin
            new_word = r_wkey[255 - 32*r_wi[2:0] -: 32];
        end else begin
            new_word = old_w ^ x_w;
        end
    end

    always_comb begin
        raddr = i_cmd.enc_start ? 4'd0 : r_rnd + 4'd1;
        rk    = {r_rk_rd[0], r_rk_rd[1], r_rk_rd[2], r_rk_rd[3]};
        done  = r_ebusy && (r_rnd == nr);
        blk   = aes_round(r_s, (r_rnd == nr)) ^ rk;
        for (int i = 0; i < 16; i++) begin
            masked[127-8*i -: 8] = (5'(i) < r_n) ? blk[127-8*i -: 8] : 8'h00;
        end
    end

    always_comb begin
        n_wkey  = r_wkey;
        n_mode  = r_mode;
        n_ctr   = r_ctr;
        n_pend  = r_pend;
        n_dirty = r_dirty;
        n_kbusy = r_kbusy;
        n_wi    = r_wi;
        n_wj    = r_wj;
        n_rcon  = r_rcon;
        n_ebusy = r_ebusy;
        n_rnd   = r_rnd;
        n_s     = r_s;
        n_act   = r_act;
        n_n     = r_n;
        n_eor   = r_eor;
        n_ovalid = r_ovalid && i_out_stall;
        n_out   = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY0: begin
                    n_wkey  = {i_cfg_data, r_cfg_key[1], r_cfg_key[2], r_cfg_key[3]};
                    n_mode  = r_cfg_size;
                    n_dirty = 1'b1;
                end
                CFG_SEED_HI: begin
                    n_ctr = {i_cfg_data, r_cfg_seed_lo};
                end
                default: begin
                    n_ctr = r_ctr;
                end
            endcase
        end

        if (i_cmd.kexp_start) begin
            n_kbusy = 1'b1;
            n_wi    = 6'd0;
            n_wj    = 3'd0;
            n_rcon  = 8'h01;
        end else if (r_kbusy) begin
            n_wi = r_wi + 6'd1;
            n_wj = (r_wj == nk[2:0] - 3'd1) ? 3'd0 : r_wj + 3'd1;
            if (r_wi >= {2'b00, nk} && r_wj == 3'd0) begin
                n_rcon = xt(r_rcon);
            end
            if (r_wi == last_wi) begin
                n_kbusy = 1'b0;
                n_dirty = 1'b0;
            end
        end

        if (i_cmd.enc_start) begin
            n_ebusy = 1'b1;
            n_rnd   = 4'd0;
            n_act   = i_cmd.act;
            n_n     = i_cmd.n;
            n_eor   = i_cmd.eor;
        end else if (r_ebusy) begin
            n_rnd = r_rnd + 4'd1;
            if (r_rnd == 4'd0) begin
                n_s = r_ctr ^ rk;
            end else begin
                n_s = blk;
            end
            if (done) begin
                n_ebusy = 1'b0;
                n_ctr   = r_ctr + 128'd1;
                case (r_act)
                    ACT_OUT: begin
                        n_ovalid = 1'b1;
                        n_out.stream_high = masked[127:64];
                        n_out.stream_low  = masked[63:0];
                        n_out.valid_count = r_n;
                        n_out.final_block = r_eor;
                    end
                    ACT_REPLACE: begin
                        n_ctr = blk;
                    end
                    ACT_NEWKEY: begin
                        n_pend = blk;
                    end
                    default: begin
                        n_ctr   = blk;
                        n_wkey  = {r_pend, 128'd0};
                        n_mode  = 2'd0;
                        n_dirty = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_kbusy) begin
            r_rk_mem[r_wi[1:0]][r_wi[5:2]] <= new_word;
        end
        for (int b = 0; b < 4; b++) begin
            r_rk_rd[b] <= r_rk_mem[b][raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_kbusy) begin
            r_win[0] <= new_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
        r_s    <= n_s;
        r_pend <= n_pend;
        r_out  <= n_out;
        r_act  <= n_act;
        r_n    <= n_n;
        r_eor  <= n_eor;
        r_wi   <= n_wi;
        r_wj   <= n_wj;
        r_rcon <= n_rcon;
        r_rnd  <= n_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cfg_key[k] <= 64'd0;
            end
            r_cfg_size    <= 2'd0;
            r_cfg_seed_lo <= 64'd0;
            r_wkey   <= 256'd0;
            r_mode   <= 2'd0;
            r_ctr    <= 128'd0;
            r_dirty  <= 1'b1;
            r_kbusy  <= 1'b0;
            r_ebusy  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY0:     r_cfg_key[0] <= i_cfg_data;
                    CFG_KEY1:     r_cfg_key[1] <= i_cfg_data;
                    CFG_KEY2:     r_cfg_key[2] <= i_cfg_data;
                    CFG_KEY3:     r_cfg_key[3] <= i_cfg_data;
                    CFG_KEY_SIZE: r_cfg_size <= i_cfg_data[1:0];
                    CFG_SEED_LO:  r_cfg_seed_lo <= i_cfg_data;
                    default:      r_cfg_size <= r_cfg_size;
                endcase
            end
            r_wkey   <= n_wkey;
            r_mode   <= n_mode;
            r_ctr    <= n_ctr;
            r_dirty  <= n_dirty;
            r_kbusy  <= n_kbusy;
            r_ebusy  <= n_ebusy;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stat.key_dirty = r_dirty;
    assign o_stat.kexp_busy = r_kbusy;
    assign o_stat.enc_done  = done;
    assign o_stat.out_full  = r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

/* test/aesctr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-CTR keystream checker
// Watches the configuration port and both item channels, predicts each
// keystream block with its own AES-CTR model and compares it field by field.
// ----------------------------------------------------------------------------
module aesctr_checker
    import aesctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [7:0] sbox [256];
    logic [63:0] cfg_key [4];
    logic [1:0]  cfg_size;
    logic [63:0] cfg_seed [2];
    logic [63:0] wkey [4];
    logic [1:0]  wmode;
    logic [127:0] ctr;
    int unsigned blocks_run;
    t_out_item expected_blocks [$];

    initial begin
        sbox = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    end

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] t);
        return {sbox[t[31:24]], sbox[t[23:16]], sbox[t[15:8]], sbox[t[7:0]]};
    endfunction

    // Byte 0 of a block is bits 127:120.
    function automatic logic [127:0] encrypt_block(logic [127:0] pt);
        logic [31:0] w [60];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3;
        logic [31:0] x;
        logic [127:0] res;
        int nk, nr;
        rc = 8'h01;
        nk = (wmode == 2'd0) ? 4 : (wmode == 2'd1) ? 6 : 8;
        nr = nk + 6;
        for (int i = 0; i < nk; i++) begin
            w[i] = (i % 2 == 0) ? wkey[i / 2][63:32] : wkey[i / 2][31:0];
        end
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            x = w[i - 1];
            if (i % nk == 0) begin
                x = sub_word({x[23:0], x[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (nk > 6 && i % nk == 4) begin
                x = sub_word(x);
            end
            w[i] = w[i - nk] ^ x;
        end
        for (int i = 0; i < 16; i++) begin
            s[i] = pt[127 - 8 * i -: 8] ^ w[i / 4][31 - 8 * (i % 4) -: 8];
        end
        for (int r = 1; r <= nr; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 4; k++) begin
                    t[4 * c + k] = sbox[s[4 * ((c + k) % 4) + k]];
                end
            end
            if (r != nr) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                    t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                    t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                    t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
                end
            end
            for (int i = 0; i < 16; i++) begin
                s[i] = t[i] ^ w[4 * r + i / 4][31 - 8 * (i % 4) -: 8];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = s[i];
        end
        return res;
    endfunction

    function automatic logic [127:0] next_keystream();
        logic [127:0] b;
        b = encrypt_block(ctr);
        ctr = ctr + 128'd1;
        return b;
    endfunction

    task automatic replace_counter();
        ctr = next_keystream();
    endtask

    task automatic predict_item(t_in_item it);
        logic [127:0] b;
        logic [127:0] k;
        int n;
        t_out_item o;
        n = (it.byte_count > 16) ? 16 : it.byte_count;
        if (n == 16) begin
            b = next_keystream();
            blocks_run++;
            if (blocks_run >= SEGMENT_BLOCKS) begin
                replace_counter();
                blocks_run = 0;
            end
        end else if (n > 0) begin
            if (blocks_run > 0) replace_counter();
            b = next_keystream();
            replace_counter();
            blocks_run = 0;
        end
        if (n > 0) begin
            for (int i = n; i < 16; i++) b[127 - 8 * i -: 8] = 8'h00;
            o.stream_high = b[127:64];
            o.stream_low = b[63:0];
            o.valid_count = 5'(n);
            o.final_block = it.end_of_request;
            expected_blocks.push_back(o);
        end
        if (it.end_of_request) begin
            if (blocks_run > 0) replace_counter();
            blocks_run = 0;
            k = next_keystream();
            b = next_keystream();
            wkey[0] = k[127:64];
            wkey[1] = k[63:0];
            wkey[2] = '0;
            wkey[3] = '0;
            wmode = 2'd0;
            ctr = b;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            cfg_key = '{default: '0};
            cfg_size = '0;
            cfg_seed = '{default: '0};
            wkey = '{default: '0};
            wmode = '0;
            ctr = '0;
            blocks_run = 0;
            expected_blocks.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                        cfg_key[i_cfg_idx[1:0]] = i_cfg_data;
                        if (i_cfg_idx == CFG_KEY0) begin
                            wkey = cfg_key;
                            wmode = cfg_size;
                        end
                    end
                    CFG_KEY_SIZE: cfg_size = i_cfg_data[1:0];
                    CFG_SEED_HI, CFG_SEED_LO: begin
                        cfg_seed[(i_cfg_idx == CFG_SEED_LO) ? 1'b1 : 1'b0] = i_cfg_data;
                        if (i_cfg_idx == CFG_SEED_HI) ctr = {cfg_seed[0], cfg_seed[1]};
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected item %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_blocks.pop_front();
                    if (e != i_out_data) begin
                        if (e.stream_high != i_out_data.stream_high)
                            $error("stream_high: expected %h, got %h",
                                   e.stream_high, i_out_data.stream_high);
                        if (e.stream_low != i_out_data.stream_low)
                            $error("stream_low: expected %h, got %h",
                                   e.stream_low, i_out_data.stream_low);
                        if (e.valid_count != i_out_data.valid_count)
                            $error("valid_count: expected %0d, got %0d",
                                   e.valid_count, i_out_data.valid_count);
                        if (e.final_block != i_out_data.final_block)
                            $error("final_block: expected %0d, got %0d",
                                   e.final_block, i_out_data.final_block);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_blocks.size();
    end

endmodule

/* test/tb_aes_ctr_keystream_generator_rekeying_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-CTR keystream generator testbench
// Drives directed and random block requests under several key and counter
// settings and idle patterns; the checker predicts and compares each block.
// ----------------------------------------------------------------------------
module tb_aes_ctr_keystream_generator_rekeying_top;
    import aesctr_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    aes_ctr_keystream_generator_rekeying_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    aesctr_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** aes_ctr_keystream_generator_rekeying_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(logic [4:0] count, logic eor);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{byte_count: count, end_of_request: eor};
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [1:0] size, logic [63:0] k0, logic [63:0] k1,
                                logic [63:0] k2, logic [63:0] k3,
                                logic [63:0] s_hi, logic [63:0] s_lo);
        write_reg(CFG_KEY_SIZE, {62'd0, size});
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_SEED_LO, s_lo);
        write_reg(CFG_SEED_HI, s_hi);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_requests(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 8) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_request((i == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16,
                                 i == len - 1);
                    sent++;
                end
            end else begin
                send_request(5'($urandom_range(0, 31)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        int idle_pairs [4][2];
        idle_pairs = '{'{0, 0}, '{70, 0}, '{0, 70}, '{6, 6}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(5'd16, 1'b0);
        send_request(5'd16, 1'b0);
        send_request(5'd5, 1'b0);
        send_request(5'd1, 1'b0);
        send_request(5'd16, 1'b0);
        send_request(5'd0, 1'b0);
        send_request(5'd0, 1'b1);
        send_request(5'd31, 1'b0);
        send_request(5'd17, 1'b1);
        send_request(5'd15, 1'b1);
        send_request(5'd16, 1'b1);
        drain();
        load_setting(2'd2, '1, '1, '1, '1, '1, '1);
        send_request(5'd16, 1'b0);
        send_request(5'd16, 1'b0);
        send_request(5'd8, 1'b1);
        drain();
        load_setting(2'd3, 64'h0123456789abcdef, 64'hfedcba9876543210,
                     64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, '1, 64'hfffffffffffffffe);
        send_request(5'd16, 1'b0);
        send_request(5'd16, 1'b1);
        drain();
        load_setting(2'd1, rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        send_request(5'd16, 1'b0);
        drain();
        write_reg(CFG_SEED_HI, rand64());
        write_reg(CFG_KEY0, rand64());
        send_request(5'd3, 1'b1);
        drain();

        for (int p = 0; p < 12; p++) begin
            send_idle_pct = idle_pairs[p % 4][0];
            recv_stall_pct = idle_pairs[p % 4][1];
            load_setting(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64(),
                         rand64(), rand64());
            random_requests(105);
            drain();
        end

        if (fail_count == 0) begin
            $display("** aes_ctr_keystream_generator_rekeying_top: PASSED **");
        end else begin
            $display("** aes_ctr_keystream_generator_rekeying_top: FAILED **");
        end
        $finish;
    end

endmodule
